@@ rtl/atpg_pkg.sv @@
// Package for the asymmetric triangle phase generator: constants, types, controller states.
// No dependencies.
`default_nettype none
package atpg_pkg;
  localparam int unsigned MaxPassesDef = 4;
  localparam int unsigned PhaseFracDef = 22;
  localparam int unsigned BaseRateW = 23;
  localparam int unsigned FmDepthW = 16;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned FmW = 16;
  localparam int unsigned PhaseW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 23;
  localparam logic [CfgIdxW-1:0] CfgBaseRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFmDepth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLoopMode = 2'd2;
  localparam logic [BaseRateW-1:0] BaseRateRst = 23'd209715;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOVE, ST_STEP, ST_MUL, ST_DIV, ST_SAT, ST_OUT
  } atpg_state_e;

  typedef struct packed {
    logic load;      // capture input and compute initial move
    logic sat_init;  // saturate initial move
    logic step;      // apply move to position, classify
    logic mul;       // overshoot times new scale
    logic div_start;
    logic div_sat;   // saturate quotient into move
    logic finish;    // commit phase and build result
  } atpg_cmd_t;

  typedef struct packed {
    logic need_carry; // step produced a nonzero rescale request
    logic move_zero;
    logic div_done;
  } atpg_sts_t;
endpackage
`default_nettype wire

@@ rtl/atpg_ctrl.sv @@
// Controller state machine of the phase generator.
// Depends on atpg_pkg.
`default_nettype none
module atpg_ctrl import atpg_pkg::*; #(
  parameter int unsigned MaxPasses = MaxPassesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_busy_i,
  input  wire atpg_sts_t sts_i,
  output atpg_cmd_t      cmd_o
);
  localparam int unsigned PassW = $clog2(MaxPasses + 1);
  atpg_state_e state_q, state_d;
  logic [PassW-1:0] pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q <= '0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pass_d = '0;
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd_o.sat_init = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.move_zero || pass_q == PassW'(MaxPasses)) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.step = 1'b1;
          pass_d = pass_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts_i.need_carry) begin
          cmd_o.mul = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (sts_i.div_done) begin
          cmd_o.div_sat = 1'b1;
          state_d = ST_STEP;
        end
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pass_q <= PassW'(MaxPasses))
    else $error("pass count beyond limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == ST_IDLE)
    else $error("finish did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MOVE)
    else $error("load did not start move");
endmodule
`default_nettype wire

@@ rtl/atpg_div.sv @@
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
// Depends on atpg_pkg.
`default_nettype none
module atpg_div import atpg_pkg::*; #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [NumW-1:0] num_i,
  input  wire logic [DenW-1:0]        den_i,
  output logic                        done_o,
  output logic signed [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] rem_q, quo_q;
  logic [DenW-1:0] den_q;
  logic neg_q, busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0] trial;
  logic [NumW-1:0] rem_sh;

  assign rem_sh = {rem_q[NumW-2:0], quo_q[NumW-1]};
  assign trial = {1'b0, rem_sh[DenW-1:0]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  // remainder stays below den, so only its low DenW+1 bits matter
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[NumW-1] ? NumW'(-num_i) : num_i;
      neg_q <= num_i[NumW-1];
      den_q <= den_i;
    end else if (busy_q) begin
      if (rem_sh[DenW] || !trial[DenW]) begin
        rem_q <= NumW'(trial[DenW-1:0]);
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

@@ rtl/atpg_dp.sv @@
// Datapath of the phase generator: config registers, move arithmetic, phase register.
// Depends on atpg_pkg and atpg_div.
`default_nettype none
module atpg_dp import atpg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic [ScaleW-1:0]    rise_scale_i,
  input  wire logic [ScaleW-1:0]    fall_scale_i,
  input  wire logic signed [FmW-1:0] fm_sample_i,
  input  wire atpg_cmd_t            cmd_i,
  output atpg_sts_t                 sts_o,
  output logic [PhaseW-1:0]         phase_o,
  output logic                      falling_o,
  output logic                      cut_o
);
  localparam int unsigned PhaseFrac = PhaseFracDef;
  localparam int unsigned MoveW = PhaseFrac + 10;  // holds +-2^(F+8) plus add growth
  localparam int unsigned ProdW = MoveW + ScaleW + 1;
  localparam int unsigned PosW = PhaseFrac + 3;
  localparam logic signed [MoveW-1:0] MoveLim = MoveW'(1) <<< (PhaseFrac + 8);
  localparam logic signed [PosW-1:0] PhOne = PosW'(1) <<< PhaseFrac;

  logic [BaseRateW-1:0] base_rate_q;
  logic [FmDepthW-1:0] fm_depth_q;
  logic loop_mode_q;
  logic [ScaleW-1:0] rise_q, fall_q, num_sc_q, den_sc_q;
  logic signed [MoveW+2:0] raw_q;
  logic signed [MoveW-1:0] move_q, ovr_q;
  logic signed [PosW-1:0] pos_q, phase_q;
  logic falling_q, phase_fall_q, cut_q, carry_q;
  logic signed [ProdW-1:0] prod_q;
  logic div_done;
  logic signed [ProdW-1:0] quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rate_q <= BaseRateRst;
      fm_depth_q <= '0;
      loop_mode_q <= 1'b1;
      phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBaseRate: base_rate_q <= cfg_data_i[BaseRateW-1:0];
          CfgFmDepth: fm_depth_q <= cfg_data_i[FmDepthW-1:0];
          CfgLoopMode: loop_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.finish) phase_q <= pos_q;
    end
  end

  // initial move terms
  logic [ScaleW-1:0] rise_nz, fall_nz, sel_sc;
  logic [BaseRateW+ScaleW-1:0] rate_prod;
  logic signed [FmW+FmDepthW:0] fm_prod;
  logic signed [MoveW+2:0] rate_term, fm_term;
  assign rise_nz = (rise_scale_i == '0) ? ScaleW'(1) : rise_scale_i;
  assign fall_nz = (fall_scale_i == '0) ? ScaleW'(1) : fall_scale_i;
  assign sel_sc = phase_q[PosW-1] ? fall_nz : rise_nz;
  assign rate_prod = base_rate_q * sel_sc;
  assign fm_prod = fm_sample_i * $signed({1'b0, fm_depth_q});
  assign rate_term = (MoveW+3)'(rate_prod >> 15);
  // arithmetic shift right floors
  assign fm_term = (MoveW+3)'(fm_prod >>> (30 - PhaseFrac));

  // step logic; the sum is kept wide since a move can far exceed one half-cycle
  logic signed [MoveW:0] npos;
  logic signed [PosW-1:0] pos_n;
  logic signed [MoveW-1:0] ovr_n;
  logic fall_n, carry_n;
  logic [ScaleW-1:0] num_n, den_n;
  assign npos = (MoveW+1)'(pos_q) + (MoveW+1)'(move_q);
  always_comb begin
    pos_n = PosW'(npos);
    fall_n = falling_q;
    carry_n = 1'b0;
    ovr_n = '0;
    num_n = fall_q;
    den_n = rise_q;
    if (!falling_q) begin
      if (npos >= PhOne) begin
        carry_n = 1'b1;
        ovr_n = MoveW'(npos - PhOne);
        pos_n = -PhOne;
        fall_n = 1'b1;
      end else if (npos < 0) begin
        if (loop_mode_q) begin
          carry_n = 1'b1;
          ovr_n = MoveW'(npos);
          fall_n = 1'b1;
        end
        pos_n = '0;
      end
    end else begin
      num_n = rise_q;
      den_n = fall_q;
      if (npos >= 0) begin
        carry_n = loop_mode_q;
        ovr_n = MoveW'(npos);
        pos_n = '0;
        fall_n = 1'b0;
      end else if (npos < -PhOne) begin
        carry_n = 1'b1;
        ovr_n = MoveW'(npos + PhOne);
        pos_n = PhOne;
        fall_n = 1'b0;
      end
    end
  end

  atpg_div #(.NumW(ProdW), .DenW(ScaleW)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i(prod_q),
    .den_i(den_sc_q),
    .done_o(div_done),
    .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rise_q <= rise_nz;
      fall_q <= fall_nz;
      raw_q <= rate_term + fm_term;
      pos_q <= phase_q;
      falling_q <= phase_q[PosW-1];
      cut_q <= 1'b0;
      carry_q <= 1'b0;
    end
    if (cmd_i.sat_init) begin
      if (raw_q > (MoveW+3)'(MoveLim)) begin
        move_q <= MoveLim; cut_q <= 1'b1;
      end else if (raw_q < -(MoveW+3)'(MoveLim)) begin
        move_q <= -MoveLim; cut_q <= 1'b1;
      end else begin
        move_q <= MoveW'(raw_q);
      end
    end
    if (cmd_i.step) begin
      pos_q <= pos_n;
      falling_q <= fall_n;
      carry_q <= carry_n && (ovr_n != '0);
      ovr_q <= ovr_n;
      num_sc_q <= num_n;
      den_sc_q <= den_n;
      move_q <= '0;
    end
    if (cmd_i.mul) prod_q <= ovr_q * $signed({1'b0, num_sc_q});
    if (cmd_i.div_sat) begin
      if (quo > ProdW'(MoveLim)) begin
        move_q <= MoveLim; cut_q <= 1'b1;
      end else if (quo < -ProdW'(MoveLim)) begin
        move_q <= -MoveLim; cut_q <= 1'b1;
      end else begin
        move_q <= MoveW'(quo);
      end
    end
  end

  assign sts_o.need_carry = carry_q;
  assign sts_o.move_zero = (move_q == '0);
  assign sts_o.div_done = div_done;
  assign phase_o = PhaseW'(pos_q);
  assign falling_o = pos_q[PosW-1];
  assign cut_o = cut_q || (move_q != '0);
endmodule
`default_nettype wire

@@ rtl/asymmetric_triangle_phase_gen.sv @@
// Asymmetric triangle phase generator: top level with output register.
// Depends on atpg_pkg, atpg_ctrl, atpg_dp.
//
// Usage: each input transfer carries rise_scale_i, fall_scale_i and fm_sample_i
// for one audio sample. The block advances its internal phase and returns one
// result transfer with phase_out_o, in_falling_half_o and remainder_dropped_o.
// Configuration (base_rate, fm_depth, loop_mode) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so only while the block is idle,
// which the block does not enforce. From input transfer to result the
// controller runs load, initial saturation and a step; every wrap pass that
// carries overshoot adds step, multiply, divider start and the 57-step
// restoring divider that rescales it. The divider sets the rate; the next
// input is accepted only once the controller is back in idle, which it enters
// as the result is registered. in_ready_o is high only when the controller is idle.
// The result sits in an output register; a new item can be accepted while it
// waits, and the controller holds in its final state only if a newer result
// would overwrite one not yet taken.
// Reset clears the phase to zero, loads the register defaults and empties the
// output register.
`default_nettype none
module asymmetric_triangle_phase_gen import atpg_pkg::*; #(
  parameter int unsigned MaxPasses = MaxPassesDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ScaleW-1:0]     rise_scale_i,
  input  wire logic [ScaleW-1:0]     fall_scale_i,
  input  wire logic signed [FmW-1:0] fm_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [PhaseW-1:0]   phase_out_o,
  output logic                       in_falling_half_o,
  output logic                       remainder_dropped_o
);
  atpg_cmd_t cmd;
  atpg_sts_t sts;
  logic [PhaseW-1:0] ph;
  logic fall, cut, out_valid_q;
  logic signed [PhaseW-1:0] phase_q;
  logic fall_q, cut_q;

  atpg_ctrl #(.MaxPasses(MaxPasses)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(out_valid_q && !out_ready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  atpg_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .rise_scale_i, .fall_scale_i, .fm_sample_i,
    .cmd_i(cmd), .sts_o(sts), .phase_o(ph), .falling_o(fall), .cut_o(cut)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      phase_q <= $signed(ph);
      fall_q <= fall;
      cut_q <= cut;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_out_o = phase_q;
  assign in_falling_half_o = fall_q;
  assign remainder_dropped_o = cut_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(phase_q))
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> fall_q == phase_q[PhaseW-1])
    else $error("falling flag disagrees with sign");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten");
endmodule
`default_nettype wire
